/* hw/rtl/sorted_key_table_top_macros.svh */
// Assertion macros for the sorted key table.
// Used by sorted_key_table_top; expects signals named clk and rst in scope.
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define SKT_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define SKT_CHECK_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define SKT_CHECK(lbl, cond, msg)
`define SKT_CHECK_NEXT(lbl, trig, cons, msg)
`endif
`endif

/* hw/rtl/skt_pkg.sv */
// Shared types and constants for the sorted key table.
// No dependencies; imported by skt_store and sorted_key_table_top.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  // Field widths of the stream payloads
  localparam int CMD_W       = 3;
  localparam int KEY_IN_W    = 32;
  localparam int PAY_IN_W    = 64;
  localparam int STAT_W      = 3;
  localparam int LEN_W       = 7;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_PAD_W   = OUT_TDATA_W - STAT_W - KEY_IN_W - PAY_IN_W - LEN_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ITER_RESET = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ITER_NEXT  = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STAT_W-1:0] ST_END     = 3'd4;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_RESOLVE  = 8'b0000_0100,
    S_SHUP     = 8'b0000_1000,
    S_SHDN     = 8'b0001_0000,
    S_ITER_RD  = 8'b0010_0000,
    S_ITER_CAP = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  // Strobes from the sequencer to the record store
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic pay_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/skt_store.sv */
// Record store: key and payload memories, one write and one read port each.
// Depends on skt_pkg for mem_ctl_t.
`timescale 1ns / 1ps
`default_nettype none

module skt_store
  import skt_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int KW    = 32,
  parameter int PW    = 64
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [KW-1:0] wr_key,
  input  logic [PW-1:0] wr_pay,
  output logic [KW-1:0] rd_key,
  output logic [PW-1:0] rd_pay
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [PW-1:0] pay_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.pay_we) begin
      pay_mem[wr_addr] <= wr_pay;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_pay <= pay_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_key_table_top.sv */
// Sorted key table top level: command sequencer, output register, assertions.
// Depends on skt_pkg, skt_store and sorted_key_table_top_macros.svh.
//
// The table holds up to CAPACITY records (a key plus a payload word) in
// ascending key order, in two single-port-read memories. One request is
// handled at a time. Clear, iterator reset, a full-table insert and the
// unused command code go straight to the result. Insert, delete, lookup and
// replace scan the keys from index 0 at one memory read per cycle. The scan
// stops at the first key not below the requested one, or once every entry
// has been read. Insert then shifts the larger entries up one slot, and
// delete shifts the later entries down, again one read per cycle. The shift
// covers the entries from where the scan stopped to the end of the list.
// Next item reads and captures the entry at the iterator position, or
// reports the end of the list without a read. A stalled master side holds
// the sequencer in its result state until the output register is free. A
// new request is taken as soon as the sequencer returns to idle, even while
// the previous result still waits on the master side. Keys and payloads use
// their low KEY_BITS and PAYLOAD_BITS bits. Memory contents are not
// cleared at reset, and entries at or above the length are never read
// into a result.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_top
  import skt_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // cmd[2:0], key[34:3], payload[98:35], zero pad[103:99]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[2:0], key_out[34:3], payload_out[98:35], length[105:99], zero pad[111:106]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int PW = PAYLOAD_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  // Request fields
  logic [CMD_W-1:0] in_cmd;
  logic [KW-1:0]    in_key;
  logic [PW-1:0]    in_pay;

  assign in_cmd = s_tdata[CMD_W-1:0];
  assign in_key = s_tdata[CMD_W +: KW];
  assign in_pay = s_tdata[CMD_W + KEY_IN_W +: PW];

  state_t state;

  // Latched request
  logic [CMD_W-1:0] req_cmd;
  logic [KW-1:0]    req_key;
  logic [PW-1:0]    req_pay;

  // Table state
  logic [CW-1:0] count;
  logic [CW-1:0] iter_pos;

  // Scan and shift bookkeeping
  logic [CW-1:0] scan_idx;
  logic          rd_valid;
  logic [CW-1:0] pos;
  logic          hit;
  logic [CW-1:0] sh_idx;
  logic [CW-1:0] sh_dec;
  logic          wr_pend;
  logic [AW-1:0] wr_addr_q;

  // Pending result and output register
  logic [STAT_W-1:0] res_status;
  logic [KW-1:0]     res_key;
  logic [PW-1:0]     res_pay;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [KEY_IN_W-1:0] out_key;
  logic [PAY_IN_W-1:0] out_pay;
  logic [LEN_W-1:0]  out_len;

  // Store interface
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [PW-1:0] wr_pay;
  logic [KW-1:0] rd_key;
  logic [PW-1:0] rd_pay;

  logic scan_ge;
  logic scan_end;
  logic out_free;

  // Terms watched by the assertions
  logic rw_clash;
  logic shifting;
  logic ins_done;

  skt_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .KW    (KW),
    .PW    (PW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_pay  (wr_pay),
    .rd_key  (rd_key),
    .rd_pay  (rd_pay)
  );

  // The scan stops at the first stored key not below the requested one,
  // or when every entry below the length has been read.
  assign scan_ge  = rd_valid && (rd_key >= req_key);
  assign scan_end = !scan_ge && (scan_idx == count);
  assign sh_dec   = sh_idx - CW'(1);
  assign out_free = !out_valid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {OUT_PAD_W'(0), out_len, out_pay, out_key, out_status};

  assign rw_clash = mem_ctl.rd_en && (mem_ctl.key_we || mem_ctl.pay_we) &&
                    (rd_addr == wr_addr);
  assign shifting = (state == S_SHUP) || (state == S_SHDN);
  assign ins_done = (state == S_SHUP) && !wr_pend && (sh_idx == pos);

  // Memory port control
  always_comb begin
    mem_ctl = '0;
    rd_addr = scan_idx[AW-1:0];
    wr_addr = wr_addr_q;
    wr_key  = rd_key;
    wr_pay  = rd_pay;
    unique case (state)
      S_SCAN: begin
        if (!scan_ge && !scan_end) begin
          mem_ctl.rd_en = 1'b1;
        end
      end
      S_RESOLVE: begin
        if (req_cmd == CMD_REPLACE && hit) begin
          mem_ctl.pay_we = 1'b1;
          wr_addr        = pos[AW-1:0];
          wr_pay         = req_pay;
        end
      end
      S_SHUP: begin
        // Read entry i-1 and write it to entry i in the following cycle
        if (sh_idx > pos) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = sh_dec[AW-1:0];
        end
        if (wr_pend) begin
          mem_ctl.key_we = 1'b1;
          mem_ctl.pay_we = 1'b1;
        end else if (sh_idx == pos) begin
          // Gap is open: drop the new record in
          mem_ctl.key_we = 1'b1;
          mem_ctl.pay_we = 1'b1;
          wr_addr        = pos[AW-1:0];
          wr_key         = req_key;
          wr_pay         = req_pay;
        end
      end
      S_SHDN: begin
        // Read entry i+1 and write it to entry i in the following cycle
        if (sh_idx < count) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = sh_idx[AW-1:0];
        end
        if (wr_pend) begin
          mem_ctl.key_we = 1'b1;
          mem_ctl.pay_we = 1'b1;
        end
      end
      S_ITER_RD: begin
        if (iter_pos < count) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = iter_pos[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      iter_pos  <= '0;
      rd_valid  <= 1'b0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the taken result unless a new one replaces it in this cycle
      if (out_valid && m_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_cmd    <= in_cmd;
            req_key    <= in_key;
            req_pay    <= in_pay;
            res_status <= ST_OK;
            res_key    <= '0;
            res_pay    <= '0;
            scan_idx   <= '0;
            rd_valid   <= 1'b0;
            case (in_cmd) inside
              CMD_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              CMD_INSERT: begin
                if (count >= FULL_COUNT) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_DELETE, CMD_REPLACE, CMD_LOOKUP: begin
                state <= S_SCAN;
              end
              CMD_ITER_RESET: begin
                iter_pos <= '0;
                state    <= S_DONE;
              end
              CMD_ITER_NEXT: begin
                state <= S_ITER_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_ge) begin
            pos   <= scan_idx - CW'(1);
            hit   <= (rd_key == req_key);
            state <= S_RESOLVE;
          end else if (scan_end) begin
            pos   <= count;
            hit   <= 1'b0;
            state <= S_RESOLVE;
          end else begin
            scan_idx <= scan_idx + CW'(1);
            rd_valid <= 1'b1;
          end
        end
        S_RESOLVE: begin
          // Read data still holds the matching entry when hit is set
          state   <= S_DONE;
          wr_pend <= 1'b0;
          case (req_cmd)
            CMD_INSERT: begin
              if (hit) begin
                res_status <= ST_DUP;
                res_key    <= rd_key;
                res_pay    <= rd_pay;
              end else begin
                sh_idx <= count;
                state  <= S_SHUP;
              end
            end
            CMD_DELETE: begin
              if (hit) begin
                res_key <= rd_key;
                res_pay <= rd_pay;
                sh_idx  <= pos + CW'(1);
                state   <= S_SHDN;
              end else begin
                res_status <= ST_MISSING;
              end
            end
            CMD_REPLACE: begin
              if (hit) begin
                res_key <= req_key;
                res_pay <= req_pay;
              end else begin
                res_status <= ST_MISSING;
              end
            end
            CMD_LOOKUP: begin
              if (hit) begin
                res_key <= rd_key;
                res_pay <= rd_pay;
              end else begin
                res_status <= ST_MISSING;
              end
            end
            default: ;
          endcase
        end
        S_SHUP: begin
          wr_pend <= (sh_idx > pos);
          if (sh_idx > pos) begin
            wr_addr_q <= sh_idx[AW-1:0];
            sh_idx    <= sh_dec;
          end
          if (!wr_pend && sh_idx == pos) begin
            count   <= count + CW'(1);
            res_key <= req_key;
            res_pay <= req_pay;
            state   <= S_DONE;
          end
        end
        S_SHDN: begin
          wr_pend <= (sh_idx < count);
          if (sh_idx < count) begin
            wr_addr_q <= sh_dec[AW-1:0];
            sh_idx    <= sh_idx + CW'(1);
          end else if (!wr_pend) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_ITER_RD: begin
          if (iter_pos < count) begin
            state <= S_ITER_CAP;
          end else begin
            res_status <= ST_END;
            state      <= S_DONE;
          end
        end
        S_ITER_CAP: begin
          res_key  <= rd_key;
          res_pay  <= rd_pay;
          iter_pos <= iter_pos + CW'(1);
          state    <= S_DONE;
        end
        S_DONE: begin
          // Hand the result to the output register once it is free
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_key    <= KEY_IN_W'(res_key);
            out_pay    <= PAY_IN_W'(res_pay);
            out_len    <= LEN_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "sorted_key_table_top_macros.svh"

  `SKT_CHECK(a_count_bound, count <= FULL_COUNT, "record count exceeds capacity")
  `SKT_CHECK(a_no_rw_collide, !rw_clash, "read and write hit the same entry")
  `SKT_CHECK(a_key_write_shift, !mem_ctl.key_we || shifting, "key write outside a shift")
  `SKT_CHECK_NEXT(a_insert_grows, ins_done, count == $past(count) + CW'(1), "insert lost a record")

endmodule

`default_nettype wire

/* test/tb_sorted_key_table_top.sv */
// Self-checking testbench for sorted_key_table_top: directed and random command streams.
// Depends on skt_pkg and the RTL under hw/rtl; holds its own model of the sorted table.
`timescale 1ns / 1ps

module tb_sorted_key_table_top;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  // Worst request is a scan and a shift that together cover the table.
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [KEY_IN_W-1:0] KEY_TOP = '1;
  localparam logic [PAY_IN_W-1:0] PAY_TOP = '1;
  localparam int REPORT_CAP = 100;

  typedef struct {
    logic [STAT_W-1:0]   status;
    logic [KEY_IN_W-1:0] key;
    logic [PAY_IN_W-1:0] payload;
    logic [LEN_W-1:0]    length;
  } answer_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Mirror of the table contents, updated when a request is accepted
  logic [KEY_IN_W-1:0] key_mem [TABLE_DEPTH];
  logic [PAY_IN_W-1:0] pay_mem [TABLE_DEPTH];
  int                  rec_count = 0;
  int                  iter_idx = 0;

  answer_t pending_answers [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  sorted_key_table_top #(
    .CAPACITY    (TABLE_DEPTH),
    .KEY_BITS    (KEY_IN_W),
    .PAYLOAD_BITS(PAY_IN_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the stream stalls for good.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < REPORT_CAP) begin
      $display("[%0t] result error: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Index of the record holding k, or the record count when absent.
  function automatic int locate_key(input logic [KEY_IN_W-1:0] k);
    int idx;
    idx = 0;
    while (idx < rec_count && key_mem[idx] != k) idx++;
    return idx;
  endfunction

  // Apply one command to the mirror and return the answer it must produce.
  function automatic answer_t apply_command(input logic [CMD_W-1:0] op,
                                            input logic [KEY_IN_W-1:0] k,
                                            input logic [PAY_IN_W-1:0] p);
    answer_t a;
    int      pos;
    int      i;
    a.status  = ST_OK;
    a.key     = '0;
    a.payload = '0;
    case (op)
      CMD_CLEAR: begin
        rec_count = 0;
      end
      CMD_INSERT: begin
        if (rec_count >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < rec_count && key_mem[pos] < k) pos++;
          if (pos < rec_count && key_mem[pos] == k) begin
            a.status  = ST_DUP;
            a.key     = key_mem[pos];
            a.payload = pay_mem[pos];
          end else begin
            for (i = rec_count; i > pos; i--) begin
              key_mem[i] = key_mem[i-1];
              pay_mem[i] = pay_mem[i-1];
            end
            key_mem[pos] = k;
            pay_mem[pos] = p;
            rec_count++;
            a.key     = k;
            a.payload = p;
          end
        end
      end
      CMD_DELETE: begin
        pos = locate_key(k);
        if (pos >= rec_count) begin
          a.status = ST_MISSING;
        end else begin
          a.key     = key_mem[pos];
          a.payload = pay_mem[pos];
          for (i = pos; i + 1 < rec_count; i++) begin
            key_mem[i] = key_mem[i+1];
            pay_mem[i] = pay_mem[i+1];
          end
          rec_count--;
        end
      end
      CMD_REPLACE: begin
        pos = locate_key(k);
        if (pos >= rec_count) begin
          a.status = ST_MISSING;
        end else begin
          pay_mem[pos] = p;
          a.key     = k;
          a.payload = p;
        end
      end
      CMD_LOOKUP: begin
        pos = locate_key(k);
        if (pos >= rec_count) begin
          a.status = ST_MISSING;
        end else begin
          a.key     = key_mem[pos];
          a.payload = pay_mem[pos];
        end
      end
      CMD_ITER_RESET: begin
        iter_idx = 0;
      end
      CMD_ITER_NEXT: begin
        // Iterator index is never adjusted when the table changes under it
        if (iter_idx >= rec_count) begin
          a.status = ST_END;
        end else begin
          a.key     = key_mem[iter_idx];
          a.payload = pay_mem[iter_idx];
          iter_idx++;
        end
      end
      default: begin
      end
    endcase
    a.length = LEN_W'(rec_count);
    return a;
  endfunction

  // Drive one request, hold it until taken, then record its expected answer.
  task automatic send_request(input logic [CMD_W-1:0] op,
                              input logic [KEY_IN_W-1:0] k,
                              input logic [PAY_IN_W-1:0] p);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    // Occasionally stretch the gap so it lands deep inside a long scan or shift
    if (gap > 0 && $urandom_range(9) == 0) gap += $urandom_range(150);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - CMD_W - KEY_IN_W - PAY_IN_W){1'b0}}, p, k, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_answers.push_back(apply_command(op, k, p));
  endtask

  // Drop valid and hold off until every outstanding answer has returned.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Favor keys already held so lookups, deletes and duplicates hit often.
  function automatic logic [KEY_IN_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (rec_count > 0 && r < 50) return key_mem[$urandom_range(rec_count - 1)];
    if (r < 75) return KEY_IN_W'($urandom_range(127));
    if (r < 80) return ($urandom_range(1) != 0) ? KEY_TOP : '0;
    return $urandom();
  endfunction

  // Receive side: check each answer taken and randomize ready.
  always @(posedge clk) begin : result_check
    answer_t want;
    answer_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status  = m_tdata[STAT_W-1:0];
      got.key     = m_tdata[STAT_W +: KEY_IN_W];
      got.payload = m_tdata[STAT_W + KEY_IN_W +: PAY_IN_W];
      got.length  = m_tdata[STAT_W + KEY_IN_W + PAY_IN_W +: LEN_W];
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected answer, status %0d key %h",
                                  got.status, got.key));
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.key !== want.key)
          report_mismatch($sformatf("key_out %h, want %h", got.key, want.key));
        if (got.payload !== want.payload)
          report_mismatch($sformatf("payload_out %h, want %h", got.payload, want.payload));
        if (got.length !== want.length)
          report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every query against an empty table, plus the unused command code.
  task automatic test_empty_table();
    send_request(CMD_ITER_NEXT, '0, '0);
    send_request(CMD_LOOKUP, KEY_IN_W'(5), '0);
    send_request(CMD_DELETE, KEY_TOP, '0);
    send_request(CMD_REPLACE, '0, PAY_TOP);
    send_request(CMD_UNUSED, KEY_TOP, PAY_TOP);
  endtask

  // Extreme keys and payloads, duplicate refusal, a full walk, then clear.
  task automatic test_basic_records();
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, KEY_TOP, PAY_TOP);
    send_request(CMD_INSERT, 32'h8000_0000, 64'h0123_4567_89ab_cdef);
    send_request(CMD_INSERT, '0, 64'h5555_aaaa_5555_aaaa);
    send_request(CMD_ITER_RESET, KEY_TOP, PAY_TOP);
    repeat (4) send_request(CMD_ITER_NEXT, '0, '0);
    send_request(CMD_LOOKUP, KEY_TOP, '0);
    send_request(CMD_REPLACE, 32'h8000_0000, 64'hfedc_ba98_7654_3210);
    send_request(CMD_LOOKUP, 32'h8000_0000, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_DELETE, KEY_TOP, '0);
    send_request(CMD_DELETE, 32'h0001_2345, '0);
    send_request(CMD_UNUSED, '0, '0);
    send_request(CMD_CLEAR, '0, '0);
    // Iterator keeps its index across clear, so this reports end of list
    send_request(CMD_ITER_NEXT, '0, '0);
  endtask

  // Fill to capacity, hit the full refusal, walk every record, then edit.
  task automatic test_full_table();
    send_request(CMD_CLEAR, '0, '0);
    while (rec_count < TABLE_DEPTH)
      send_request(CMD_INSERT, $urandom(), {$urandom(), $urandom()});
    // Full is reported ahead of the duplicate check
    send_request(CMD_INSERT, key_mem[TABLE_DEPTH/2], '0);
    send_request(CMD_INSERT, $urandom(), '0);
    send_request(CMD_ITER_RESET, '0, '0);
    repeat (TABLE_DEPTH + 1) send_request(CMD_ITER_NEXT, '0, '0);
    send_request(CMD_DELETE, key_mem[TABLE_DEPTH-1], '0);
    send_request(CMD_DELETE, key_mem[0], '0);
    send_request(CMD_DELETE, key_mem[TABLE_DEPTH/3], '0);
    send_request(CMD_REPLACE, key_mem[7], {$urandom(), $urandom()});
    send_request(CMD_INSERT, KEY_TOP, PAY_TOP);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_ITER_NEXT, '0, '0);
    hold_until_drained();
  endtask

  // Weighted mix of commands with random content against the live table.
  task automatic test_random_traffic(input int n_items);
    int               i;
    int               r;
    logic [CMD_W-1:0] op;
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(999);
      if (r < 340)      op = CMD_INSERT;
      else if (r < 490) op = CMD_DELETE;
      else if (r < 610) op = CMD_REPLACE;
      else if (r < 760) op = CMD_LOOKUP;
      else if (r < 810) op = CMD_ITER_RESET;
      else if (r < 986) op = CMD_ITER_NEXT;
      else if (r < 992) op = CMD_CLEAR;
      else              op = CMD_UNUSED;
      send_request(op, pick_key(), {$urandom(), $urandom()});
      if ($urandom_range(199) == 0) hold_until_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender mostly busy, receiver stalls about half the time
    send_idle_pct  = 9;
    recv_stall_pct = 52;
    test_empty_table();
    test_basic_records();
    test_full_table();
    test_random_traffic(200);
    hold_until_drained();

    // Sender sparse, receiver mostly ready
    send_idle_pct  = 52;
    recv_stall_pct = 9;
    test_random_traffic(200);
    hold_until_drained();

    // Back to back in both directions
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(200);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
